FILE: rtl/psrt_pkg.sv
// Shared types, codes and constants of the periodic slot reservation table.
`timescale 1ns / 1ps

package psrt_pkg;

  // Field and register types at their fixed widths.
  typedef logic [1:0]  cmd_t;
  typedef logic [4:0]  node_t;
  typedef logic [7:0]  offset_t;
  typedef logic [8:0]  len_t;
  typedef logic [8:0]  cycle_t;
  typedef logic [5:0]  height_t;
  typedef logic [8:0]  gc_t;
  typedef logic [5:0]  rows_t;
  typedef logic [20:0] sum_t;
  typedef logic [1:0]  status_t;
  typedef logic [0:0]  cfg_idx_t;
  typedef logic [8:0]  cfg_data_t;

  // Internal widths: first row (node * height), step count and linear base address.
  typedef logic [10:0] frow_t;
  typedef logic [14:0] step_t;
  typedef logic [19:0] base_t;

  // Shared divider operand width.
  localparam int DIV_W = 9;
  typedef logic [DIV_W-1:0] div_t;

  // Commands.
  localparam cmd_t CMD_RESERVE = 2'd0;
  localparam cmd_t CMD_RELEASE = 2'd1;
  localparam cmd_t CMD_CLEAR   = 2'd2;

  // Result status codes.
  localparam status_t STATUS_OK         = 2'd0;
  localparam status_t STATUS_CYCLE_ZERO = 2'd1;
  localparam status_t STATUS_ROWS       = 2'd2;
  localparam status_t STATUS_SAT        = 2'd3;

  // Configuration register indexes.
  localparam cfg_idx_t REG_HYPERPERIOD = 1'b0;
  localparam cfg_idx_t REG_NODE_ROWS   = 1'b1;

  // Register reset values and the collision total ceiling.
  localparam gc_t   GC_RESET   = 9'd256;
  localparam rows_t ROWS_RESET = 6'd32;
  localparam sum_t  SUM_MAX    = 21'h1FFFFF;

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    ST_CLEAR = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_ROWS  = 11'b000_0000_0100,
    ST_CHECK = 11'b000_0000_1000,
    ST_DIVQ  = 11'b000_0001_0000,
    ST_DIVR  = 11'b000_0010_0000,
    ST_MUL   = 11'b000_0100_0000,
    ST_START = 11'b000_1000_0000,
    ST_WALK  = 11'b001_0000_0000,
    ST_DRAIN = 11'b010_0000_0000,
    ST_DONE  = 11'b100_0000_0000
  } state_e;

endpackage

FILE: rtl/periodic_slot_reservation_table_top.sv
// Top level of the periodic slot reservation table: sequencer, cell update and result register.
//
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_ready_o   cmd, node, offset, length, cycle, height, last_hop
// out      output     out_valid_o/out_ready_i collision_total, status, flow_done
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A reserve or release walks length * (hyperperiod / cycle) * height cells: the walk does
// one read-modify-write of the count memory per cell, and the setup runs the shared divider
// twice. A clear sweeps every cell of the memory, MAX_SLOTS * MAX_ROWS cells (8192 at the
// defaults). After reset the same sweep runs before the first item is taken. The input side
// accepts a new item while a result still waits on a stalled output.
`timescale 1ns / 1ps

module periodic_slot_reservation_table_top #(
  parameter int MAX_SLOTS   = 256,
  parameter int MAX_ROWS    = 32,
  parameter int COUNT_WIDTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Item channel.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  psrt_pkg::cmd_t      cmd_i,
  input  psrt_pkg::node_t     node_i,
  input  psrt_pkg::offset_t   offset_i,
  input  psrt_pkg::len_t      length_i,
  input  psrt_pkg::cycle_t    cycle_i,
  input  psrt_pkg::height_t   height_i,
  input  logic                last_hop_i,
  // Result channel.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output psrt_pkg::sum_t      collision_total_o,
  output psrt_pkg::status_t   status_o,
  output logic                flow_done_o,
  // Configuration channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  psrt_pkg::cfg_idx_t  cfg_index_i,
  input  psrt_pkg::cfg_data_t cfg_data_i
);

  localparam int CELL_COUNT = MAX_SLOTS * MAX_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  psrt_pkg::state_e state_q, state_d;

  // Configuration registers and their clamped values.
  psrt_pkg::gc_t   gc_q, gc_d, gc_eff;
  psrt_pkg::rows_t rows_q, rows_d, rows_eff;

  // Item fields held for the duration of the item.
  psrt_pkg::cmd_t    cmd_q, cmd_d;
  psrt_pkg::node_t   node_q, node_d;
  psrt_pkg::offset_t offset_q, offset_d;
  psrt_pkg::len_t    length_q, length_d;
  psrt_pkg::cycle_t  cycle_q, cycle_d;
  psrt_pkg::height_t height_q, height_d;
  logic              last_q, last_d;
  psrt_pkg::status_t status_q, status_d;

  // Setup values of the walk.
  psrt_pkg::frow_t first_row_q, first_row_d;
  psrt_pkg::div_t  quo_q, quo_d;
  psrt_pkg::step_t steps_q, steps_d;
  addr_t           base_q, base_d;

  // Walk counters.
  psrt_pkg::len_t   i_q, i_d, i_inc;
  psrt_pkg::step_t  j_q, j_d, j_inc;
  psrt_pkg::cycle_t r_q, r_d, r_inc, r_wrap;
  addr_t            addr_q, addr_d;

  // Update stage: the cell whose read data arrives this cycle.
  logic   s1_valid_q, s1_valid_d;
  addr_t  s1_addr_q, s1_addr_d;
  logic   s1_fwd_q, s1_fwd_d;
  count_t wdata_q;

  // Clearing sweep.
  addr_t clr_addr_q, clr_addr_d;
  logic  clr_resp_q, clr_resp_d;

  psrt_pkg::sum_t sum_q, sum_d;

  // Result register.
  logic              out_valid_q, out_valid_d;
  psrt_pkg::sum_t    out_total_q, out_total_d;
  psrt_pkg::status_t out_status_q, out_status_d;
  logic              out_done_q, out_done_d;

  // Divider hookup.
  logic           div_start;
  psrt_pkg::div_t div_dividend;
  logic           div_done;
  psrt_pkg::div_t div_quo;
  psrt_pkg::div_t div_rem;

  // Memory hookup.
  logic   ram_we;
  addr_t  ram_waddr;
  count_t ram_wdata;
  count_t ram_rdata;

  // Cell update results.
  count_t         cur_count;
  count_t         new_count;
  psrt_pkg::sum_t sum_upd;
  logic           cell_sat;

  logic in_xfer;
  logic out_xfer;

  assign in_ready_o  = (state_q == psrt_pkg::ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_q && out_ready_i;
  assign cfg_ready_o = 1'b1;

  // Registers above the table size act as the table size.
  assign gc_eff   = (32'(gc_q) > 32'(MAX_SLOTS)) ? psrt_pkg::gc_t'(MAX_SLOTS) : gc_q;
  assign rows_eff = (32'(rows_q) > 32'(MAX_ROWS)) ? psrt_pkg::rows_t'(MAX_ROWS) : rows_q;

  // Configuration writes.
  always_comb begin
    gc_d   = gc_q;
    rows_d = rows_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        psrt_pkg::REG_HYPERPERIOD: gc_d   = cfg_data_i;
        psrt_pkg::REG_NODE_ROWS:   rows_d = cfg_data_i[5:0];
        default:                   gc_d   = gc_q;
      endcase
    end
  end

  // Walk step increments.
  assign i_inc  = i_q + psrt_pkg::len_t'(1);
  assign j_inc  = j_q + psrt_pkg::step_t'(1);
  assign r_inc  = r_q + psrt_pkg::cycle_t'(1);
  assign r_wrap = (r_inc == cycle_q) ? '0 : r_inc;

  // Cell update: take the count just written when the same cell was read behind it.
  assign cur_count = s1_fwd_q ? wdata_q : ram_rdata;

  always_comb begin
    new_count = cur_count;
    sum_upd   = sum_q;
    cell_sat  = 1'b0;
    if (cmd_q == psrt_pkg::CMD_RESERVE) begin
      if (cur_count == COUNT_MAX) begin
        cell_sat = 1'b1;
      end else begin
        new_count = cur_count + count_t'(1);
        if ((cur_count != '0) && (sum_q != psrt_pkg::SUM_MAX)) begin
          sum_upd = sum_q + psrt_pkg::sum_t'(1);
        end
      end
    end else begin
      if (cur_count == '0) begin
        cell_sat = 1'b1;
      end else begin
        new_count = cur_count - count_t'(1);
        if ((cur_count > count_t'(1)) && (sum_q != '0)) begin
          sum_upd = sum_q - psrt_pkg::sum_t'(1);
        end
      end
    end
  end

  // Memory write port is shared by the clearing sweep and the cell update.
  assign ram_we    = s1_valid_q || (state_q == psrt_pkg::ST_CLEAR);
  assign ram_waddr = (state_q == psrt_pkg::ST_CLEAR) ? clr_addr_q : s1_addr_q;
  assign ram_wdata = (state_q == psrt_pkg::ST_CLEAR) ? '0 : new_count;

  // The divider first gives hyperperiod / cycle, then offset modulo cycle.
  assign div_dividend = (state_q == psrt_pkg::ST_DIVQ) ? psrt_pkg::div_t'(offset_q) : gc_eff;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    node_d      = node_q;
    offset_d    = offset_q;
    length_d    = length_q;
    cycle_d     = cycle_q;
    height_d    = height_q;
    last_d      = last_q;
    status_d    = status_q;
    first_row_d = first_row_q;
    quo_d       = quo_q;
    steps_d     = steps_q;
    base_d      = base_q;
    i_d         = i_q;
    j_d         = j_q;
    r_d         = r_q;
    addr_d      = addr_q;
    s1_valid_d  = 1'b0;
    s1_addr_d   = addr_q;
    s1_fwd_d    = s1_valid_q && (s1_addr_q == addr_q);
    clr_addr_d  = clr_addr_q;
    clr_resp_d  = clr_resp_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && !out_xfer;
    out_total_d = out_total_q;
    out_status_d = out_status_q;
    out_done_d  = out_done_q;

    unique case (state_q)
      psrt_pkg::ST_CLEAR: begin
        clr_addr_d = clr_addr_q + addr_t'(1);
        if (clr_addr_q == addr_t'(CELL_COUNT - 1)) begin
          state_d = clr_resp_q ? psrt_pkg::ST_DONE : psrt_pkg::ST_IDLE;
        end
      end
      psrt_pkg::ST_IDLE: begin
        if (in_xfer) begin
          cmd_d    = cmd_i;
          node_d   = node_i;
          offset_d = offset_i;
          length_d = length_i;
          cycle_d  = cycle_i;
          height_d = height_i;
          last_d   = last_hop_i;
          status_d = psrt_pkg::STATUS_OK;
          unique case (cmd_i)
            psrt_pkg::CMD_RESERVE, psrt_pkg::CMD_RELEASE: begin
              if (cycle_i == '0) begin
                status_d = psrt_pkg::STATUS_CYCLE_ZERO;
                state_d  = psrt_pkg::ST_DONE;
              end else begin
                state_d = psrt_pkg::ST_ROWS;
              end
            end
            psrt_pkg::CMD_CLEAR: begin
              clr_addr_d = '0;
              clr_resp_d = 1'b1;
              state_d    = psrt_pkg::ST_CLEAR;
            end
            default: begin
              state_d = psrt_pkg::ST_DONE;
            end
          endcase
        end
      end
      psrt_pkg::ST_ROWS: begin
        first_row_d = psrt_pkg::frow_t'(node_q) * psrt_pkg::frow_t'(height_q);
        state_d     = psrt_pkg::ST_CHECK;
      end
      psrt_pkg::ST_CHECK: begin
        if ((first_row_q + psrt_pkg::frow_t'(height_q)) > psrt_pkg::frow_t'(rows_eff)) begin
          status_d = psrt_pkg::STATUS_ROWS;
          state_d  = psrt_pkg::ST_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = psrt_pkg::ST_DIVQ;
        end
      end
      psrt_pkg::ST_DIVQ: begin
        if (div_done) begin
          quo_d     = div_quo;
          div_start = 1'b1;
          state_d   = psrt_pkg::ST_DIVR;
        end
      end
      psrt_pkg::ST_DIVR: begin
        if (div_done) begin
          r_d     = div_rem;
          state_d = psrt_pkg::ST_MUL;
        end
      end
      psrt_pkg::ST_MUL: begin
        steps_d = psrt_pkg::step_t'(quo_q) * psrt_pkg::step_t'(height_q);
        base_d  = addr_t'(psrt_pkg::base_t'(first_row_q) * psrt_pkg::base_t'(gc_eff));
        state_d = psrt_pkg::ST_START;
      end
      psrt_pkg::ST_START: begin
        i_d    = '0;
        j_d    = '0;
        addr_d = base_q + addr_t'(r_q);
        if ((length_q == '0) || (steps_q == '0)) begin
          state_d = psrt_pkg::ST_DONE;
        end else begin
          state_d = psrt_pkg::ST_WALK;
        end
      end
      psrt_pkg::ST_WALK: begin
        // Read one cell per cycle; the update stage writes it back in the next cycle.
        s1_valid_d = 1'b1;
        if (j_inc == steps_q) begin
          j_d    = '0;
          i_d    = i_inc;
          r_d    = r_wrap;
          addr_d = base_q + addr_t'(r_wrap);
          if (i_inc == length_q) begin
            state_d = psrt_pkg::ST_DRAIN;
          end
        end else begin
          j_d    = j_inc;
          addr_d = addr_q + addr_t'(cycle_q);
        end
      end
      psrt_pkg::ST_DRAIN: begin
        state_d = psrt_pkg::ST_DONE;
      end
      psrt_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_total_d  = sum_q;
          out_status_d = status_q;
          out_done_d   = last_q;
          clr_resp_d   = 1'b0;
          state_d      = psrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = psrt_pkg::ST_IDLE;
      end
    endcase

    // A saturated cell marks the whole hop.
    if (s1_valid_q && cell_sat) begin
      status_d = psrt_pkg::STATUS_SAT;
    end
  end

  // Collision total follows the cell updates and is emptied by the sweep.
  always_comb begin
    sum_d = sum_q;
    if (state_q == psrt_pkg::ST_CLEAR) begin
      sum_d = '0;
    end else if (s1_valid_q) begin
      sum_d = sum_upd;
    end
  end

  psrt_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (cycle_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  psrt_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (CELL_COUNT)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psrt_pkg::ST_CLEAR;
      gc_q        <= psrt_pkg::GC_RESET;
      rows_q      <= psrt_pkg::ROWS_RESET;
      sum_q       <= '0;
      clr_addr_q  <= '0;
      clr_resp_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gc_q        <= gc_d;
      rows_q      <= rows_d;
      sum_q       <= sum_d;
      clr_addr_q  <= clr_addr_d;
      clr_resp_q  <= clr_resp_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    node_q       <= node_d;
    offset_q     <= offset_d;
    length_q     <= length_d;
    cycle_q      <= cycle_d;
    height_q     <= height_d;
    last_q       <= last_d;
    status_q     <= status_d;
    first_row_q  <= first_row_d;
    quo_q        <= quo_d;
    steps_q      <= steps_d;
    base_q       <= base_d;
    i_q          <= i_d;
    j_q          <= j_d;
    r_q          <= r_d;
    addr_q       <= addr_d;
    s1_addr_q    <= s1_addr_d;
    s1_fwd_q     <= s1_fwd_d;
    wdata_q      <= new_count;
    out_total_q  <= out_total_d;
    out_status_q <= out_status_d;
    out_done_q   <= out_done_d;
  end

  assign out_valid_o       = out_valid_q;
  assign collision_total_o = out_total_q;
  assign status_o          = out_status_q;
  assign flow_done_o       = out_done_q;

endmodule

FILE: rtl/psrt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module psrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read; a read of the entry being written returns the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/psrt_div.sv
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
`timescale 1ns / 1ps

module psrt_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  psrt_pkg::div_t    dividend_i,
  input  psrt_pkg::div_t    divisor_i,
  output logic              done_o,
  output psrt_pkg::div_t    quotient_o,
  output psrt_pkg::div_t    remainder_o
);

  localparam int CNT_W = $clog2(psrt_pkg::DIV_W + 1);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  psrt_pkg::div_t         quo_q, quo_d;
  psrt_pkg::div_t         rem_q, rem_d;
  psrt_pkg::div_t         dsr_q, dsr_d;
  logic [psrt_pkg::DIV_W:0] shifted;
  logic [psrt_pkg::DIV_W:0] diff;
  logic                   fits;

  // One restoring step: shift in the next dividend bit and subtract if it fits.
  assign shifted = {rem_q, quo_q[psrt_pkg::DIV_W-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(psrt_pkg::DIV_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[psrt_pkg::DIV_W-2:0], fits};
      rem_d = fits ? diff[psrt_pkg::DIV_W-1:0] : shifted[psrt_pkg::DIV_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule
